// ===== src/spot_pkg.sv =====
// shared types and constants for the shape pair overlap test
package spot_pkg;

    localparam int POINT_BITS = 48;
    localparam int RAD_BITS   = 16;
    localparam int TSUM_BITS  = RAD_BITS + 1;
    localparam int TSQ_BITS   = 2 * TSUM_BITS;

    typedef enum logic [1:0] {
        MODE_SS   = 2'd0,
        MODE_SB   = 2'd1,
        MODE_BB   = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    // load enables of the two front stages
    typedef struct packed {
        logic s1;
        logic s2;
    } t_adv;

endpackage

// ===== src/spot_if.sv =====
// valid/ready channels carrying shape pairs and hit flags
interface spot_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [47:0] a_first_point;
    logic [47:0] a_second_point;
    logic [15:0] a_radius;
    logic [47:0] b_first_point;
    logic [47:0] b_second_point;
    logic [15:0] b_radius;

    modport source (
        output valid, mode, a_first_point, a_second_point, a_radius,
               b_first_point, b_second_point, b_radius,
        input  ready
    );
    modport sink (
        input  valid, mode, a_first_point, a_second_point, a_radius,
               b_first_point, b_second_point, b_radius,
        output ready
    );
endinterface

interface spot_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// ===== src/shape_pair_overlap_test_top.sv =====
// top level of the shape pair overlap test pipeline
// Shape pair overlap test. One transfer on i_in carries a mode and two shapes
// (sphere center and radius, or two box corners, coordinates signed Q8.8 of
// COORD_BITS each: x at bit 0, y at COORD_BITS, z at 2*COORD_BITS; point bits
// above 3*COORD_BITS are ignored, missing ones read as zero). One transfer on
// o_out returns the hit flag: sphere-sphere hits when the squared center
// distance is below (ra+rb)^2, sphere-box when the summed squared gaps are
// below ra^2, box-box when the intervals overlap on all three axes (touching
// and enclosing count), mode 3 never hits. The pipeline is four register
// stages deep (corner ordering, gap or distance per axis, squaring, sum and
// compare); each result passes through them in order and a new pair is taken
// every cycle unless the output stalls. Each stage holds its item while the
// one after it is full and stalled; an empty stage keeps loading, so bubbles
// are squeezed out and input is still taken while a finished result waits.
module shape_pair_overlap_test_top import spot_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spot_in_if.sink     i_in,
    spot_out_if.source  o_out
);

    localparam int CB     = COORD_BITS;
    localparam int EXT_W  = 3 * CB + POINT_BITS;
    localparam int SQ_W   = 2 * CB;
    localparam int CMP_W  = (2 * CB + 2 > TSQ_BITS) ? 2 * CB + 2 : TSQ_BITS;

    // per-stage load enables, a stage loads when empty or when it drains
    logic ce1, ce2, ce3, ce4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign ce4 = !r_v4 || o_out.ready;
    assign ce3 = !r_v3 || ce4;
    assign ce2 = !r_v2 || ce3;
    assign ce1 = !r_v1 || ce2;

    assign i_in.ready = ce1;

    t_adv w_adv;
    assign w_adv.s1 = ce1;
    assign w_adv.s2 = ce2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ce1) r_v1 <= i_in.valid;
            if (ce2) r_v2 <= r_v1;
            if (ce3) r_v3 <= r_v2;
            if (ce4) r_v4 <= r_v3;
        end
    end

    // coordinate unpacking, zero fill above the 48 point bits
    logic [EXT_W-1:0] w_a1, w_a2, w_b1, w_b2;
    assign w_a1 = {{(3*CB){1'b0}}, i_in.a_first_point};
    assign w_a2 = {{(3*CB){1'b0}}, i_in.a_second_point};
    assign w_b1 = {{(3*CB){1'b0}}, i_in.b_first_point};
    assign w_b2 = {{(3*CB){1'b0}}, i_in.b_second_point};

    // mode and radius threshold travel alongside the axis lanes
    t_mode                r_mode1, r_mode2, r_mode3;
    logic [TSUM_BITS-1:0] r_t1, r_t2;
    logic [TSUM_BITS-1:0] n_t1;
    t_mode                n_mode;

    assign n_mode = t_mode'(i_in.mode);

    always_comb begin
        // sphere-sphere compares against the radius sum, sphere-box against ra
        if (n_mode == MODE_SS) begin
            n_t1 = TSUM_BITS'(i_in.a_radius) + TSUM_BITS'(i_in.b_radius);
        end else begin
            n_t1 = TSUM_BITS'(i_in.a_radius);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce1) begin
            r_mode1 <= n_mode;
            r_t1    <= n_t1;
        end
        if (ce2) begin
            r_mode2 <= r_mode1;
            r_t2    <= r_t1;
        end
    end

    // three axis lanes, stages 1 and 2
    logic [CB-1:0] w_mag [3];
    logic [2:0]    w_sep;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        spot_axis #(
            .COORD_BITS (CB)
        ) u_axis (
            .i_clk     (i_clk),
            .i_adv     (w_adv),
            .i_mode_s1 (r_mode1),
            .i_a1      (w_a1[k*CB +: CB]),
            .i_a2      (w_a2[k*CB +: CB]),
            .i_b1      (w_b1[k*CB +: CB]),
            .i_b2      (w_b2[k*CB +: CB]),
            .o_mag     (w_mag[k]),
            .o_sep     (w_sep[k])
        );
    end

    // stage 3: squares of the per-axis magnitudes and of the threshold
    logic [SQ_W-1:0]     r_sq [3];
    logic [TSQ_BITS-1:0] r_tsq;
    logic                r_sep3;

    always_ff @(posedge i_clk) begin
        if (ce3) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SQ_W'(w_mag[k]) * SQ_W'(w_mag[k]);
            end
            r_tsq   <= TSQ_BITS'(r_t2) * TSQ_BITS'(r_t2);
            r_sep3  <= |w_sep;
            r_mode3 <= r_mode2;
        end
    end

    // stage 4: sum of squares against threshold, select by mode
    logic [CMP_W-1:0] n_sum;
    logic             n_hit;
    logic             r_hit;

    always_comb begin
        n_sum = CMP_W'(r_sq[0]) + CMP_W'(r_sq[1]) + CMP_W'(r_sq[2]);
        case (r_mode3)
            MODE_SS, MODE_SB: begin
                n_hit = n_sum < CMP_W'(r_tsq);
            end
            MODE_BB: begin
                n_hit = !r_sep3;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce4) begin
            r_hit <= n_hit;
        end
    end

    assign o_out.valid = r_v4;
    assign o_out.hit   = r_hit;

    // unused mode never reports a hit
    a_none_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && ce4 && (r_mode3 == MODE_NONE) |=> !o_out.hit)
        else $error("mode 3 item produced a hit");

    // zero threshold never hits for sphere modes
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && ce4 && (r_tsq == '0) && ((r_mode3 == MODE_SS) || (r_mode3 == MODE_SB))
        |=> !o_out.hit)
        else $error("zero radius sphere produced a hit");

    // an open output always lets the front accept
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output is ready");

    // a stalled first stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !ce2 |=> r_v1 && $stable(r_mode1))
        else $error("stalled stage 1 item lost");

endmodule

// ===== src/spot_axis.sv =====
// per-axis front end: corner ordering, then magnitude to square and box separation
module spot_axis import spot_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  t_adv                         i_adv,
    input  t_mode                        i_mode_s1,
    input  logic signed [COORD_BITS-1:0] i_a1,
    input  logic signed [COORD_BITS-1:0] i_a2,
    input  logic signed [COORD_BITS-1:0] i_b1,
    input  logic signed [COORD_BITS-1:0] i_b2,
    output logic        [COORD_BITS-1:0] o_mag,
    output logic                         o_sep
);

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] r_alo, r_ahi, r_blo, r_bhi, r_ac;
    logic signed [CB:0]   r_d;
    logic        [CB-1:0] r_mag;
    logic                 r_sep;

    logic signed [CB-1:0] n_alo, n_ahi, n_blo, n_bhi;
    logic signed [CB:0]   n_d, n_dneg, n_glo, n_ghi;
    logic        [CB-1:0] n_mag;
    logic                 n_sep;

    // stage 1: order corners, center difference
    always_comb begin
        n_alo = (i_a1 <= i_a2) ? i_a1 : i_a2;
        n_ahi = (i_a1 <= i_a2) ? i_a2 : i_a1;
        n_blo = (i_b1 <= i_b2) ? i_b1 : i_b2;
        n_bhi = (i_b1 <= i_b2) ? i_b2 : i_b1;
        n_d   = (CB+1)'(i_a1) - (CB+1)'(i_b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_alo <= n_alo;
            r_ahi <= n_ahi;
            r_blo <= n_blo;
            r_bhi <= n_bhi;
            r_ac  <= i_a1;
            r_d   <= n_d;
        end
    end

    // stage 2: magnitude per mode, interval separation
    always_comb begin
        n_dneg = -r_d;
        n_glo  = (CB+1)'(r_blo) - (CB+1)'(r_ac);
        n_ghi  = (CB+1)'(r_ac) - (CB+1)'(r_bhi);
        n_mag  = '0;
        case (i_mode_s1)
            MODE_SS: begin
                n_mag = r_d[CB] ? n_dneg[CB-1:0] : r_d[CB-1:0];
            end
            MODE_SB: begin
                if (r_ac < r_blo) begin
                    n_mag = n_glo[CB-1:0];
                end else if (r_ac > r_bhi) begin
                    n_mag = n_ghi[CB-1:0];
                end
            end
            default: begin
                n_mag = '0;
            end
        endcase
        n_sep = (r_alo > r_bhi) || (r_blo > r_ahi);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_mag <= n_mag;
            r_sep <= n_sep;
        end
    end

    assign o_mag = r_mag;
    assign o_sep = r_sep;

endmodule
